// File: rtl/core/tract_recombination_merge_unit_assert.svh
// Assertion macros for the tract recombination merge unit.
// Included by the top-level RTL file, which carries the concurrent assertions; needs no package.
`ifndef TRACT_RECOMBINATION_MERGE_UNIT_ASSERT_SVH
`define TRACT_RECOMBINATION_MERGE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define TRM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define TRM_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define TRM_ASSERT(lbl, clk, rst, prop)
`define TRM_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/core/tcm_pkg.sv
// Shared types and constants of the tract recombination merge unit.
// Used by the top level and the divider; depends on nothing.
package tcm_pkg;

   localparam int MAX_MUTS   = 32;
   localparam int MAX_TRACTS = 16;
   localparam int MUT_AW     = (MAX_MUTS > 1) ? $clog2(MAX_MUTS) : 1;
   localparam int MUT_CW     = $clog2(MAX_MUTS + 1);
   localparam int TR_AW      = (MAX_TRACTS > 1) ? $clog2(MAX_TRACTS) : 1;
   localparam int TR_CW      = $clog2(MAX_TRACTS + 1);

   localparam int POS_W = 32;
   localparam int ID_W  = 16;
   localparam int LEN_W = 16;
   localparam int LC_W  = 16;
   localparam int BND_W = POS_W + 1;
   localparam int QUO_W = LEN_W + POS_W;
   localparam int MUT_W = POS_W + ID_W;
   localparam int TR_W  = 2 * BND_W;

   localparam logic [LC_W-1:0]  LC_RESET = 16'd1024;
   localparam logic [BND_W-1:0] END_TOP  = {BND_W{1'b1}};

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] ADDR_LOCUS = 3'd0;

   typedef enum logic [1:0] {
      KIND_RECIP = 2'd0,
      KIND_DONOR = 2'd1,
      KIND_TRACT = 2'd2,
      KIND_RUN   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [POS_W-1:0]       position;
      logic [ID_W-1:0]        mutation_id;
      logic [LEN_W-1:0]       tract_length;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]        out_mutation_id;
      logic [POS_W-1:0]       out_position;
      logic                   from_donor;
      logic                   last_item;
   } rsp_type;

endpackage

// File: rtl/core/tcm_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module tcm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tcm_div.sv
// Restoring divider for the tract length fraction: (length * 2^32) / divisor.
// One quotient bit per cycle; uses tcm_pkg.
module tcm_div
   import tcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [LEN_W-1:0]  length,
   input  logic [LC_W-1:0]   divisor,
   output logic              done,
   output logic [QUO_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(QUO_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [LC_W-1:0]   rem_ff, rem_in;
   logic [LC_W-1:0]   dvs_ff, dvs_in;
   logic [LC_W:0]     trial;
   logic [LC_W:0]     diff;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = {length, {POS_W{1'b0}}};
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], fits};
         rem_in = fits ? diff[LC_W-1:0] : trial[LC_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/tract_recombination_merge_unit.sv
// Top level of the tract recombination merge unit.
// Uses tcm_pkg, tcm_ram, tcm_div and the assertion macro header.

// This block builds a new haplotype from a recipient mutation list, a donor
// mutation list and a set of conversion tracts. Each input word is either a
// load (recipient mutation, donor mutation, tract) or a run command. Mutation
// loads are taken one per cycle while the unit is idle and written into two
// 32-entry memories. A tract load computes its end as start + length * 2^32 /
// locus_count with a bit-serial divider, and the input stalls until the
// divider is done; the end saturates at the top of Q1.32 and tracts of zero
// length are skipped. Loads beyond the store capacity are dropped. A run
// command sorts the tracts by start with a selection scan over the tract
// memory, fuses overlapping and nested tracts on the fly, and walks the two
// mutation memories: recipient mutations outside the tracts and donor
// mutations inside them come out as result words in position order, the
// last one flagged with last_item. Each mutation step waits for the
// registered memory read after the index has moved. The input stays stalled
// for the whole run; at its end all stores are empty again. The result
// channel has one output register plus one holding register, so a stalled
// output only pauses the walk. locus_count is written at byte address 0 of
// the register port; a value of zero acts as one.

`include "tract_recombination_merge_unit_assert.svh"

module tract_recombination_merge_unit
   import tcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV, ST_SREQ, ST_SCMP, ST_PICK, ST_WS, ST_WE, ST_TAIL, ST_FLUSH
   } state_type;

   state_type          state_ff, state_in;
   logic [LC_W-1:0]    lcount_ff, lcount_in;
   logic [MUT_CW-1:0]  rcnt_ff, rcnt_in, dcnt_ff, dcnt_in;
   logic [TR_CW-1:0]   tcnt_ff, tcnt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   // Selection scan state.
   logic [TR_AW-1:0]   tptr_ff, tptr_in;
   logic [BND_W-1:0]   last_s_ff, last_s_in;
   logic [TR_AW-1:0]   last_i_ff, last_i_in;
   logic               have_last_ff, have_last_in;
   logic [BND_W-1:0]   best_s_ff, best_s_in, best_e_ff, best_e_in;
   logic [TR_AW-1:0]   best_i_ff, best_i_in;
   logic               best_v_ff, best_v_in;

   // Fused tract being built and tract being walked.
   logic [BND_W-1:0]   cur_s_ff, cur_s_in, cur_e_ff, cur_e_in;
   logic               cur_v_ff, cur_v_in;
   logic [BND_W-1:0]   wk_s_ff, wk_s_in, wk_e_ff, wk_e_in;

   // Walk indexes and read-data freshness.
   logic [MUT_CW-1:0]  s1_ff, s1_in, s2_ff, s2_in;
   logic               rok_ff, rok_in, dok_ff, dok_in;

   rsp_type            pend_ff, pend_in, rsp_ff, rsp_in;
   logic               pend_v_ff, pend_v_in, rsp_v_ff, rsp_v_in;

   logic               accept, out_free, push_out, new_res_v;
   rsp_type            out_word, new_res;
   logic               r_wr_en, d_wr_en, t_wr_en, div_start, div_done;
   logic [MUT_W-1:0]   r_rd, d_rd;
   logic [TR_W-1:0]    t_rd;
   logic [QUO_W-1:0]   quo;
   logic [QUO_W:0]     end_sum;
   logic [BND_W-1:0]   end_sat;
   logic [LC_W-1:0]    divisor;
   logic [POS_W-1:0]   rpos, dpos;
   logic [ID_W-1:0]    rid, did;
   logic [BND_W-1:0]   td_s, td_e;
   logic               r_more, d_more, scan_last, cand, better, csr_wr;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign divisor  = (lcount_ff == '0) ? LC_W'(1) : lcount_ff;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_LOCUS) ? {{(32 - LC_W){1'b0}}, lcount_ff} : '0;

   assign rpos = r_rd[MUT_W-1:ID_W];
   assign rid  = r_rd[ID_W-1:0];
   assign dpos = d_rd[MUT_W-1:ID_W];
   assign did  = d_rd[ID_W-1:0];
   assign td_s = t_rd[TR_W-1:BND_W];
   assign td_e = t_rd[BND_W-1:0];

   assign r_more    = s1_ff < rcnt_ff;
   assign d_more    = s2_ff < dcnt_ff;
   assign scan_last = TR_CW'(tptr_ff) == (tcnt_ff - TR_CW'(1));
   assign cand      = !have_last_ff || (td_s > last_s_ff) ||
                      ((td_s == last_s_ff) && (tptr_ff > last_i_ff));
   assign better    = !best_v_ff || (td_s < best_s_ff);

   assign end_sum = {{(QUO_W + 1 - POS_W){1'b0}}, pos_ff} + {1'b0, quo};
   assign end_sat = (|end_sum[QUO_W:BND_W]) ? END_TOP : end_sum[BND_W-1:0];

   assign out_free = !rsp_v_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      lcount_in    = lcount_ff;
      rcnt_in      = rcnt_ff;
      dcnt_in      = dcnt_ff;
      tcnt_in      = tcnt_ff;
      pos_in       = pos_ff;
      tptr_in      = tptr_ff;
      last_s_in    = last_s_ff;
      last_i_in    = last_i_ff;
      have_last_in = have_last_ff;
      best_s_in    = best_s_ff;
      best_e_in    = best_e_ff;
      best_i_in    = best_i_ff;
      best_v_in    = best_v_ff;
      cur_s_in     = cur_s_ff;
      cur_e_in     = cur_e_ff;
      cur_v_in     = cur_v_ff;
      wk_s_in      = wk_s_ff;
      wk_e_in      = wk_e_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      rok_in       = 1'b1;
      dok_in       = 1'b1;
      pend_in      = pend_ff;
      pend_v_in    = pend_v_ff;
      rsp_in       = rsp_ff;
      rsp_v_in     = rsp_v_ff;
      push_out     = 1'b0;
      out_word     = pend_ff;
      new_res_v    = 1'b0;
      new_res      = '0;
      r_wr_en      = 1'b0;
      d_wr_en      = 1'b0;
      t_wr_en      = 1'b0;
      div_start    = 1'b0;

      if (csr_wr && (csr_paddr == ADDR_LOCUS)) begin
         lcount_in = csr_pwdata[LC_W-1:0];
      end
      if (rsp_v_ff && !rsp_stall) begin
         rsp_v_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  KIND_RECIP: begin
                     if (rcnt_ff < MUT_CW'(MAX_MUTS)) begin
                        r_wr_en = 1'b1;
                        rcnt_in = rcnt_ff + MUT_CW'(1);
                     end
                  end
                  KIND_DONOR: begin
                     if (dcnt_ff < MUT_CW'(MAX_MUTS)) begin
                        d_wr_en = 1'b1;
                        dcnt_in = dcnt_ff + MUT_CW'(1);
                     end
                  end
                  KIND_TRACT: begin
                     if ((req_data.tract_length != '0) &&
                         (tcnt_ff < TR_CW'(MAX_TRACTS))) begin
                        div_start = 1'b1;
                        pos_in    = req_data.position;
                        state_in  = ST_DIV;
                     end
                  end
                  KIND_RUN: begin
                     s1_in        = '0;
                     s2_in        = '0;
                     rok_in       = 1'b0;
                     dok_in       = 1'b0;
                     cur_v_in     = 1'b0;
                     have_last_in = 1'b0;
                     best_v_in    = 1'b0;
                     tptr_in      = '0;
                     state_in     = (tcnt_ff == '0) ? ST_TAIL : ST_SREQ;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_wr_en  = 1'b1;
               tcnt_in  = tcnt_ff + TR_CW'(1);
               state_in = ST_IDLE;
            end
         end
         ST_SREQ: begin
            state_in = ST_SCMP;
         end
         ST_SCMP: begin
            if (cand && better) begin
               best_s_in = td_s;
               best_e_in = td_e;
               best_i_in = tptr_ff;
               best_v_in = 1'b1;
            end
            if (scan_last) begin
               state_in = ST_PICK;
            end else begin
               tptr_in  = tptr_ff + TR_AW'(1);
               state_in = ST_SREQ;
            end
         end
         ST_PICK: begin
            // The next tract in start order either opens, extends or closes
            // the fused tract; a closed one is walked before the next scan.
            tptr_in   = '0;
            best_v_in = 1'b0;
            state_in  = ST_SREQ;
            if (best_v_ff) begin
               last_s_in    = best_s_ff;
               last_i_in    = best_i_ff;
               have_last_in = 1'b1;
               if (!cur_v_ff) begin
                  cur_s_in = best_s_ff;
                  cur_e_in = best_e_ff;
                  cur_v_in = 1'b1;
               end else if (cur_e_ff > best_s_ff) begin
                  if (best_e_ff > cur_e_ff) begin
                     cur_e_in = best_e_ff;
                  end
               end else begin
                  wk_s_in  = cur_s_ff;
                  wk_e_in  = cur_e_ff;
                  cur_s_in = best_s_ff;
                  cur_e_in = best_e_ff;
                  state_in = ST_WS;
               end
            end else if (cur_v_ff) begin
               wk_s_in  = cur_s_ff;
               wk_e_in  = cur_e_ff;
               cur_v_in = 1'b0;
               state_in = ST_WS;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_WS: begin
            // Before the tract: keep recipients, pass over donors.
            if (rok_ff && dok_ff) begin
               if (r_more && ({1'b0, rpos} < wk_s_ff)) begin
                  if (!pend_v_ff || out_free) begin
                     new_res_v = 1'b1;
                     new_res   = '{out_mutation_id: rid, out_position: rpos,
                                   from_donor: 1'b0, last_item: 1'b0};
                     s1_in     = s1_ff + MUT_CW'(1);
                     rok_in    = 1'b0;
                  end
               end else if (d_more && ({1'b0, dpos} < wk_s_ff)) begin
                  s2_in  = s2_ff + MUT_CW'(1);
                  dok_in = 1'b0;
               end else begin
                  state_in = ST_WE;
               end
            end
         end
         ST_WE: begin
            // Inside the tract: keep donors, pass over recipients.
            if (rok_ff && dok_ff) begin
               if (d_more && ({1'b0, dpos} < wk_e_ff)) begin
                  if (!pend_v_ff || out_free) begin
                     new_res_v = 1'b1;
                     new_res   = '{out_mutation_id: did, out_position: dpos,
                                   from_donor: 1'b1, last_item: 1'b0};
                     s2_in     = s2_ff + MUT_CW'(1);
                     dok_in    = 1'b0;
                  end
               end else if (r_more && ({1'b0, rpos} < wk_e_ff)) begin
                  s1_in  = s1_ff + MUT_CW'(1);
                  rok_in = 1'b0;
               end else begin
                  state_in = ST_SREQ;
               end
            end
         end
         ST_TAIL: begin
            if (rok_ff) begin
               if (r_more) begin
                  if (!pend_v_ff || out_free) begin
                     new_res_v = 1'b1;
                     new_res   = '{out_mutation_id: rid, out_position: rpos,
                                   from_donor: 1'b0, last_item: 1'b0};
                     s1_in     = s1_ff + MUT_CW'(1);
                     rok_in    = 1'b0;
                  end
               end else begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  push_out           = 1'b1;
                  out_word.last_item = 1'b1;
                  pend_v_in          = 1'b0;
               end
               // The walk indexes return to zero with the counts.
               rcnt_in  = '0;
               dcnt_in  = '0;
               tcnt_in  = '0;
               s1_in    = '0;
               s2_in    = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // A new result parks in the holding register so that the last word of
      // the run can still be flagged; the previous one moves to the output.
      if (new_res_v) begin
         if (pend_v_ff) begin
            push_out = 1'b1;
         end
         pend_in   = new_res;
         pend_v_in = 1'b1;
      end
      if (push_out) begin
         rsp_in   = out_word;
         rsp_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lcount_ff <= LC_RESET;
         rcnt_ff   <= '0;
         dcnt_ff   <= '0;
         tcnt_ff   <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         cur_v_ff  <= 1'b0;
         best_v_ff <= 1'b0;
         have_last_ff <= 1'b0;
         rok_ff    <= 1'b0;
         dok_ff    <= 1'b0;
         s1_ff     <= '0;
         s2_ff     <= '0;
         tptr_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         lcount_ff <= lcount_in;
         rcnt_ff   <= rcnt_in;
         dcnt_ff   <= dcnt_in;
         tcnt_ff   <= tcnt_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
         cur_v_ff  <= cur_v_in;
         best_v_ff <= best_v_in;
         have_last_ff <= have_last_in;
         rok_ff    <= rok_in;
         dok_ff    <= dok_in;
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         tptr_ff   <= tptr_in;
      end
      pos_ff    <= pos_in;
      last_s_ff <= last_s_in;
      last_i_ff <= last_i_in;
      best_s_ff <= best_s_in;
      best_e_ff <= best_e_in;
      best_i_ff <= best_i_in;
      cur_s_ff  <= cur_s_in;
      cur_e_ff  <= cur_e_in;
      wk_s_ff   <= wk_s_in;
      wk_e_ff   <= wk_e_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   tcm_ram #(.WIDTH(MUT_W), .DEPTH(MAX_MUTS)) u_recip_ram (
      .clock   (clock),
      .wr_en   (r_wr_en),
      .wr_addr (rcnt_ff[MUT_AW-1:0]),
      .wr_data ({req_data.position, req_data.mutation_id}),
      .rd_addr (s1_ff[MUT_AW-1:0]),
      .rd_data (r_rd)
   );

   tcm_ram #(.WIDTH(MUT_W), .DEPTH(MAX_MUTS)) u_donor_ram (
      .clock   (clock),
      .wr_en   (d_wr_en),
      .wr_addr (dcnt_ff[MUT_AW-1:0]),
      .wr_data ({req_data.position, req_data.mutation_id}),
      .rd_addr (s2_ff[MUT_AW-1:0]),
      .rd_data (d_rd)
   );

   tcm_ram #(.WIDTH(TR_W), .DEPTH(MAX_TRACTS)) u_tract_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (tcnt_ff[TR_AW-1:0]),
      .wr_data ({1'b0, pos_ff, end_sat}),
      .rd_addr (tptr_ff),
      .rd_data (t_rd)
   );

   tcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .length   (req_data.tract_length),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quo)
   );

   `TRM_NEVER(a_rcnt_max, clock, reset, rcnt_ff > MUT_CW'(MAX_MUTS))
   `TRM_NEVER(a_tcnt_max, clock, reset, tcnt_ff > TR_CW'(MAX_TRACTS))
   `TRM_NEVER(a_walk_span, clock, reset, (state_ff == ST_WE) && (wk_e_ff <= wk_s_ff))
   `TRM_NEVER(a_s1_bound, clock, reset, (state_ff != ST_IDLE) && (s1_ff > rcnt_ff))
   `TRM_ASSERT(a_run_clears, clock, reset, ((state_ff == ST_FLUSH) && (state_in == ST_IDLE)) |=> ((rcnt_ff == '0) && (dcnt_ff == '0) && (tcnt_ff == '0)))

endmodule
